FILE: src/tst_pkg.sv
// Package: request, status, register and sequencer codes shared by the transport.
package tst_pkg;

  typedef enum logic [2:0] {
    REQ_LOAD    = 3'd0,
    REQ_MOUNT   = 3'd1,
    REQ_READ    = 3'd2,
    REQ_WRITE   = 3'd3,
    REQ_FLUSH   = 3'd4,
    REQ_DISCARD = 3'd5,
    REQ_READOUT = 3'd6,
    REQ_BAD     = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_STATE   = 2'd1,
    STS_ARG     = 2'd2,
    STS_REFUSED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_SECTOR_COUNT = 2'd0,
    CFG_MOTOR_SELECT = 2'd1,
    CFG_WRITE_ENABLE = 2'd2,
    CFG_ERASE_ENABLE = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RBASE,
    ST_RADDR,
    ST_RFIN,
    ST_WBASE,
    ST_COPY,
    ST_WR
  } state_t;

  typedef enum logic [0:0] {
    BUF_FIN_NONE = 1'b0,
    BUF_FIN_READ = 1'b1
  } buf_fin_t;

  localparam int SEC_W         = 8;
  localparam int CFG_W         = 8;
  localparam logic [3:0] NO_MOTOR_LIMIT = 4'd7;
  localparam logic [3:0] MOTOR_OFF      = 4'd8;
  localparam logic [7:0] SECTOR_COUNT_RST = 8'd254;

endpackage

FILE: src/tst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/tape_sector_transport.sv
// Top level: looping tape-sector transport with image store and sector buffer.
//
// Each word on the input channel yields exactly one result word. A tape read steps
// through settling the position, forming the sector base with the shared
// sector-times-length multiplier (ST_RBASE), addressing the image store (ST_RADDR)
// and taking its registered read (ST_RFIN). The first write to a clean sector copies
// the whole sector from the image store into the buffer through the single store read
// port, one byte a cycle, before the byte is written; later writes skip the copy.
// After reset and after every good mount the sector buffer is swept to zero, and
// during the sweep no input word is taken (configuration writes still land). The
// block works on one word at a time and takes a new one only once the previous result
// has left the output register. The image store itself is never cleared: reading a
// byte that was never loaded returns whatever the memory holds.
module tape_sector_transport #(
  parameter int SECTOR_BYTES     = 543,
  parameter int HEADER_START     = 0,
  parameter int DATA_START       = 15,
  parameter int MAX_SECTOR_COUNT = 254,
  parameter int MIN_SECTOR_COUNT = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_we,
  input  tst_pkg::cfg_idx_t          cfg_index,
  input  logic [tst_pkg::CFG_W-1:0]  cfg_wdata,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 in_req_type,
  input  logic [17:0]                in_image_address,
  input  logic [9:0]                 in_buffer_index,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_host_accepts,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [7:0]                 out_read_byte,
  output logic [7:0]                 out_flush_sector,
  output logic                       out_dirty_flag
);

  import tst_pkg::*;

  localparam int STORE_DEPTH = MAX_SECTOR_COUNT * SECTOR_BYTES;
  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int BW  = $clog2(SECTOR_BYTES);
  localparam int OFF_TOP = (SECTOR_BYTES > 128) ? SECTOR_BYTES : 128;
  localparam int OW  = $clog2(OFF_TOP + 1);
  localparam logic [OW-1:0] OFF_SB  = OW'(SECTOR_BYTES);
  localparam logic [OW-1:0] OFF_HDR = OW'(HEADER_START);
  localparam logic [OW-1:0] OFF_DAT = OW'(DATA_START);
  localparam logic [BW-1:0] CNT_LAST = BW'(SECTOR_BYTES - 1);

  // sequencer and transport state
  state_t           state_r, state_nxt;
  logic [SEC_W-1:0] sec_r, sec_nxt;
  logic [OW-1:0]    off_r, off_nxt;
  logic             phase_r, phase_nxt;
  logic             dirty_r, dirty_nxt;
  logic             mounted_r, mounted_nxt;
  // configuration registers
  logic [7:0]       count_r, count_nxt;
  logic [3:0]       motor_r, motor_nxt;
  logic             wen_r, wen_nxt;
  logic             ers_r, ers_nxt;
  // sweep and copy control
  logic [BW-1:0]    cnt_r, cnt_nxt;
  logic             cp_run_r, cp_run_nxt;
  logic             cp_dv_r, cp_dv_nxt;
  logic [BW-1:0]    cp_idx_r, cp_idx_nxt;
  logic [AW-1:0]    base_r, base_nxt;
  logic [7:0]       dbyte_r, dbyte_nxt;
  buf_fin_t         bfin_r, bfin_nxt;
  // result register
  logic             ov_r, ov_nxt;
  logic [1:0]       os_r, os_nxt;
  logic [7:0]       ob_r, ob_nxt;
  logic [7:0]       of_r, of_nxt;
  logic             od_r, od_nxt;

  // memory ports
  logic          st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [7:0]    st_rdata;
  logic          bf_we;
  logic [BW-1:0] bf_waddr, bf_raddr;
  logic [7:0]    bf_wdata, bf_rdata;

  logic     accept;
  logic     count_ok, tape_ready;
  req_t     req;
  logic [OW-1:0] rd_off;
  logic [SEC_W-1:0] sec_wrap;

  assign req      = req_t'(in_req_type);
  assign in_stall = (state_r != ST_IDLE) || ov_r || (bfin_r != BUF_FIN_NONE);
  assign accept   = in_valid && !in_stall;

  assign count_ok   = (32'(count_r) >= MIN_SECTOR_COUNT) && (32'(count_r) <= MAX_SECTOR_COUNT);
  assign tape_ready = mounted_r && (motor_r <= NO_MOTOR_LIMIT) && count_ok && (sec_r < count_r);
  assign sec_wrap   = ((sec_r + 8'd1) == count_r) ? '0 : sec_r + 8'd1;

  assign out_valid        = ov_r;
  assign out_status       = os_r;
  assign out_read_byte    = ob_r;
  assign out_flush_sector = of_r;
  assign out_dirty_flag   = od_r;

  tst_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (in_data_byte),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  tst_ram #(.WIDTH(8), .DEPTH(SECTOR_BYTES)) u_buf (
    .clk   (clk),
    .we    (bf_we),
    .waddr (bf_waddr),
    .wdata (bf_wdata),
    .raddr (bf_raddr),
    .rdata (bf_rdata)
  );

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (req)
            REQ_MOUNT: begin
              if (count_ok) state_nxt = ST_CLEAR;
            end
            REQ_READ: begin
              if (tape_ready && (rd_off < OFF_SB)) state_nxt = ST_RBASE;
            end
            REQ_WRITE: begin
              if (tape_ready && wen_r && !ers_r) begin
                state_nxt = dirty_r ? ST_WR : ST_WBASE;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: if (cnt_r == CNT_LAST) state_nxt = ST_IDLE;
      ST_RBASE: state_nxt = ST_RADDR;
      ST_RADDR: state_nxt = ST_RFIN;
      ST_RFIN:  state_nxt = ST_IDLE;
      ST_WBASE: state_nxt = ST_COPY;
      ST_COPY:  if (!cp_run_r && cp_dv_r) state_nxt = ST_WR;
      ST_WR:    state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Read position after the header/data/next-sector step.
  always_comb begin
    rd_off = off_r;
    if (off_r >= (phase_r ? OFF_SB : OFF_DAT)) begin
      rd_off = phase_r ? OFF_HDR : OFF_DAT;
    end
  end

  // Datapath and outputs of each sequencer state.
  always_comb begin
    sec_nxt     = sec_r;
    off_nxt     = off_r;
    phase_nxt   = phase_r;
    dirty_nxt   = dirty_r;
    mounted_nxt = mounted_r;
    count_nxt   = count_r;
    motor_nxt   = motor_r;
    wen_nxt     = wen_r;
    ers_nxt     = ers_r;
    cnt_nxt     = cnt_r;
    cp_run_nxt  = cp_run_r;
    cp_dv_nxt   = 1'b0;
    cp_idx_nxt  = cnt_r;
    base_nxt    = base_r;
    dbyte_nxt   = dbyte_r;
    bfin_nxt    = BUF_FIN_NONE;
    ov_nxt      = ov_r && out_stall;
    os_nxt      = os_r;
    ob_nxt      = ob_r;
    of_nxt      = of_r;
    od_nxt      = od_r;
    st_we       = 1'b0;
    st_waddr    = AW'(in_image_address);
    st_raddr    = base_r + AW'(off_r);
    bf_we       = 1'b0;
    bf_waddr    = cnt_r;
    bf_wdata    = '0;
    bf_raddr    = BW'(in_buffer_index);

    if (cfg_we) begin
      case (cfg_index)
        CFG_SECTOR_COUNT: count_nxt = cfg_wdata;
        CFG_MOTOR_SELECT: motor_nxt = cfg_wdata[3:0];
        CFG_WRITE_ENABLE: wen_nxt   = cfg_wdata[0];
        CFG_ERASE_ENABLE: ers_nxt   = cfg_wdata[0];
        default: ;
      endcase
    end

    // deliver a buffer readout in the cycle after the address went out
    if (bfin_r == BUF_FIN_READ) begin
      ov_nxt = 1'b1;
      ob_nxt = bf_rdata;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          os_nxt    = STS_OK;
          ob_nxt    = '0;
          of_nxt    = '0;
          dbyte_nxt = in_data_byte;
          case (req)
            REQ_LOAD: begin
              if (32'(in_image_address) < STORE_DEPTH) st_we = 1'b1;
              else os_nxt = STS_ARG;
              ov_nxt = 1'b1;
              od_nxt = dirty_r;
            end
            REQ_MOUNT: begin
              ov_nxt = 1'b1;
              if (count_ok) begin
                mounted_nxt = 1'b1;
                sec_nxt     = '0;
                off_nxt     = OFF_HDR;
                phase_nxt   = 1'b0;
                dirty_nxt   = 1'b0;
                motor_nxt   = MOTOR_OFF;
                wen_nxt     = 1'b0;
                ers_nxt     = 1'b0;
                cnt_nxt     = '0;
                od_nxt      = 1'b0;
              end else begin
                os_nxt = STS_ARG;
                od_nxt = dirty_r;
              end
            end
            REQ_READ: begin
              od_nxt = dirty_r;
              if (!tape_ready) begin
                os_nxt = STS_STATE;
                ov_nxt = 1'b1;
              end else begin
                // step into the data part or on to the next sector
                if (off_r >= (phase_r ? OFF_SB : OFF_DAT)) begin
                  phase_nxt = !phase_r;
                  if (phase_r) sec_nxt = sec_wrap;
                end
                off_nxt = rd_off;
                if (rd_off >= OFF_SB) begin
                  off_nxt = rd_off + 1'b1;
                  ov_nxt  = 1'b1;
                end
              end
            end
            REQ_WRITE: begin
              od_nxt = dirty_r;
              if (!(tape_ready && wen_r && !ers_r)) begin
                os_nxt = STS_STATE;
                ov_nxt = 1'b1;
              end
            end
            REQ_FLUSH: begin
              ov_nxt = 1'b1;
              if (dirty_r) begin
                of_nxt = sec_r;
                if (in_host_accepts) dirty_nxt = 1'b0;
                else os_nxt = STS_REFUSED;
              end
              od_nxt = dirty_r && !in_host_accepts;
            end
            REQ_DISCARD: begin
              ov_nxt    = 1'b1;
              dirty_nxt = 1'b0;
              off_nxt   = OFF_HDR;
              phase_nxt = 1'b0;
              od_nxt    = 1'b0;
            end
            REQ_READOUT: begin
              od_nxt = dirty_r;
              if (32'(in_buffer_index) < SECTOR_BYTES) begin
                bfin_nxt = BUF_FIN_READ;
              end else begin
                os_nxt = STS_ARG;
                ov_nxt = 1'b1;
              end
            end
            default: begin
              os_nxt = STS_ARG;
              ov_nxt = 1'b1;
              od_nxt = dirty_r;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        bf_we    = 1'b1;
        bf_waddr = cnt_r;
        bf_wdata = '0;
        cnt_nxt  = cnt_r + 1'b1;
      end
      ST_RBASE, ST_WBASE: begin
        base_nxt   = AW'(32'(sec_r) * SECTOR_BYTES);
        cnt_nxt    = '0;
        cp_run_nxt = 1'b1;
      end
      ST_RADDR: begin
        st_raddr = base_r + AW'(off_r);
      end
      ST_RFIN: begin
        ob_nxt  = st_rdata;
        ov_nxt  = 1'b1;
        off_nxt = off_r + 1'b1;
      end
      ST_COPY: begin
        // issue one store read a cycle, write it to the buffer in the following cycle
        st_raddr   = base_r + AW'(cnt_r);
        cp_dv_nxt  = cp_run_r;
        cp_idx_nxt = cnt_r;
        if (cp_run_r) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) cp_run_nxt = 1'b0;
        end
        bf_we    = cp_dv_r;
        bf_waddr = cp_idx_r;
        bf_wdata = st_rdata;
      end
      ST_WR: begin
        dirty_nxt = 1'b1;
        od_nxt    = 1'b1;
        ov_nxt    = 1'b1;
        if (off_r >= OFF_SB) begin
          off_nxt = OFF_SB;
        end else begin
          bf_we    = 1'b1;
          bf_waddr = BW'(off_r);
          bf_wdata = dbyte_r;
          off_nxt  = off_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      sec_r     <= '0;
      off_r     <= OFF_HDR;
      phase_r   <= 1'b0;
      dirty_r   <= 1'b0;
      mounted_r <= 1'b0;
      count_r   <= SECTOR_COUNT_RST;
      motor_r   <= MOTOR_OFF;
      wen_r     <= 1'b0;
      ers_r     <= 1'b0;
      cnt_r     <= '0;
      cp_run_r  <= 1'b0;
      cp_dv_r   <= 1'b0;
      bfin_r    <= BUF_FIN_NONE;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sec_r     <= sec_nxt;
      off_r     <= off_nxt;
      phase_r   <= phase_nxt;
      dirty_r   <= dirty_nxt;
      mounted_r <= mounted_nxt;
      count_r   <= count_nxt;
      motor_r   <= motor_nxt;
      wen_r     <= wen_nxt;
      ers_r     <= ers_nxt;
      cnt_r     <= cnt_nxt;
      cp_run_r  <= cp_run_nxt;
      cp_dv_r   <= cp_dv_nxt;
      bfin_r    <= bfin_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    cp_idx_r <= cp_idx_nxt;
    base_r   <= base_nxt;
    dbyte_r  <= dbyte_nxt;
    os_r     <= os_nxt;
    ob_r     <= ob_nxt;
    of_r     <= of_nxt;
    od_r     <= od_nxt;
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("input taken while sequencer busy");

  a_dirty_from_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(dirty_r) |-> $past(state_r == ST_WR)) else $error("dirty mark set outside a write");

  a_clear_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !dirty_r) else $error("buffer dirty during clearing sweep");

  a_mount_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(mounted_r)) else $error("mount lost");

endmodule

FILE: tb/tb_top.sv
// Testbench top: drives random and directed tape requests and checks each result word.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tst_pkg::*;

  localparam int SECTOR_BYTES   = 543;
  localparam int HEADER_START   = 0;
  localparam int DATA_START     = 15;
  localparam int MAX_SECTORS    = 254;
  localparam int MIN_SECTORS    = 1;
  localparam int STORE_DEPTH    = MAX_SECTORS * SECTOR_BYTES;
  // Sectors loaded in full before any tape access; random reads never leave them.
  localparam int LOADED_SECTORS = 1;
  // Bytes loaded at the head of the next sector, for the wrap at the end.
  localparam int NEXT_HEAD      = 3;
  localparam int STALL_LIMIT    = 20000;
  localparam int CHUNKS         = 12;
  localparam int CHUNK_WORDS    = 15;

  typedef struct packed {
    req_t        req;
    logic [17:0] addr;
    logic [9:0]  bidx;
    logic [7:0]  dbyte;
    logic        accept;
  } tape_req_s;

  typedef struct packed {
    status_t     status;
    logic [7:0]  rbyte;
    logic [7:0]  fsec;
    logic        dirty;
  } tape_rsp_s;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_SECTOR_COUNT;
  logic [7:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_req_type = '0;
  logic [17:0] in_image_address = '0;
  logic [9:0] in_buffer_index = '0;
  logic [7:0] in_data_byte = '0;
  logic in_host_accepts = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_read_byte;
  logic [7:0] out_flush_sector;
  logic out_dirty_flag;

  tape_req_s pending_words[$];
  tape_rsp_s expected_rsps[$];
  int snd_idle_pct = 34;
  int rcv_stall_pct = 46;
  int mismatches = 0;
  int quiet_cycles = 0;

  // Shadow of the transport: image, buffer, head position and registers.
  logic [7:0] img_model [STORE_DEPTH];
  logic [7:0] buf_model [SECTOR_BYTES];
  int unsigned cur_sec, byte_off;
  bit data_phase, dirty, mounted;
  int unsigned sec_count, motor, wr_en, er_en;

  tape_sector_transport u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_image_address(in_image_address), .in_buffer_index(in_buffer_index),
    .in_data_byte(in_data_byte), .in_host_accepts(in_host_accepts),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_read_byte(out_read_byte), .out_flush_sector(out_flush_sector),
    .out_dirty_flag(out_dirty_flag)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit count_ok();
    return sec_count >= MIN_SECTORS && sec_count <= MAX_SECTORS;
  endfunction

  function automatic bit tape_ready();
    return mounted && motor <= NO_MOTOR_LIMIT && count_ok() && cur_sec < sec_count;
  endfunction

  function automatic logic [7:0] store_byte(int unsigned sec, int unsigned off);
    int unsigned a;
    if (off >= SECTOR_BYTES) return 8'd0;
    a = sec * SECTOR_BYTES + off;
    return a < STORE_DEPTH ? img_model[a] : 8'd0;
  endfunction

  // Sector that the next read would fetch from, after any phase or sector step.
  function automatic int unsigned read_target();
    if (data_phase && byte_off >= SECTOR_BYTES) return (cur_sec + 1) % sec_count;
    return cur_sec;
  endfunction

  task automatic model_reset();
    foreach (buf_model[i]) buf_model[i] = 8'd0;
    cur_sec = 0; byte_off = HEADER_START; data_phase = 0; dirty = 0; mounted = 0;
    sec_count = SECTOR_COUNT_RST; motor = MOTOR_OFF; wr_en = 0; er_en = 0;
  endtask

  task automatic predict_word(input tape_req_s r, output tape_rsp_s o);
    o = '{STS_OK, 8'd0, 8'd0, 1'b0};
    case (r.req)
      REQ_LOAD: begin
        if (r.addr < STORE_DEPTH) img_model[r.addr] = r.dbyte;
        else o.status = STS_ARG;
      end
      REQ_MOUNT: begin
        if (!count_ok()) begin
          o.status = STS_ARG;
        end else begin
          mounted = 1; cur_sec = 0; byte_off = HEADER_START; data_phase = 0; dirty = 0;
          foreach (buf_model[i]) buf_model[i] = 8'd0;
          motor = MOTOR_OFF; wr_en = 0; er_en = 0;
        end
      end
      REQ_READ: begin
        if (!tape_ready()) begin
          o.status = STS_STATE;
        end else begin
          if (byte_off >= (data_phase ? SECTOR_BYTES : DATA_START)) begin
            if (!data_phase) begin
              data_phase = 1; byte_off = DATA_START;
            end else begin
              cur_sec = (cur_sec + 1) % sec_count; data_phase = 0; byte_off = HEADER_START;
            end
          end
          o.rbyte = store_byte(cur_sec, byte_off);
          byte_off++;
        end
      end
      REQ_WRITE: begin
        if (!tape_ready() || wr_en == 0 || er_en != 0) begin
          o.status = STS_STATE;
        end else begin
          if (!dirty) begin
            for (int i = 0; i < SECTOR_BYTES; i++) buf_model[i] = store_byte(cur_sec, i);
            dirty = 1;
          end
          if (byte_off >= SECTOR_BYTES) begin
            byte_off = SECTOR_BYTES;
          end else begin
            buf_model[byte_off] = r.dbyte;
            byte_off++;
          end
        end
      end
      REQ_FLUSH: begin
        if (dirty) begin
          o.fsec = cur_sec[7:0];
          if (r.accept) dirty = 0;
          else o.status = STS_REFUSED;
        end
      end
      REQ_DISCARD: begin
        dirty = 0; byte_off = HEADER_START; data_phase = 0;
      end
      REQ_READOUT: begin
        if (r.bidx < SECTOR_BYTES) o.rbyte = buf_model[r.bidx];
        else o.status = STS_ARG;
      end
      default: o.status = STS_ARG;
    endcase
    o.dirty = dirty;
  endtask

  // Predict at queueing time: words reach the block in this order, and
  // register writes only happen once the pipeline has drained.
  task automatic send_word(input tape_req_s r);
    tape_rsp_s o;
    predict_word(r, o);
    pending_words.push_back(r);
    expected_rsps.push_back(o);
  endtask

  task automatic send(input req_t q, input int unsigned a, input int unsigned b,
                      input int unsigned d, input bit acc);
    tape_req_s r;
    r.req = q; r.addr = a[17:0]; r.bidx = b[9:0]; r.dbyte = d[7:0]; r.accept = acc;
    send_word(r);
  endtask

  task automatic wait_drained();
    wait (pending_words.size() == 0 && expected_rsps.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[7:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SECTOR_COUNT: sec_count = v & 8'hff;
      CFG_MOTOR_SELECT: motor = v & 4'hf;
      CFG_WRITE_ENABLE: wr_en = v & 1;
      default:          er_en = v & 1;
    endcase
  endtask

  // Random word, mostly well-formed tape traffic; never reads unloaded image bytes.
  task automatic random_word();
    tape_req_s r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.addr = ($urandom_range(0, 9) == 0) ? 18'($urandom) : 18'($urandom_range(0, STORE_DEPTH - 1));
    r.bidx = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, SECTOR_BYTES - 1));
    r.dbyte = 8'($urandom);
    r.accept = 1'($urandom_range(0, 1));
    if (pick < 8) r.req = REQ_LOAD;
    else if (pick < 10) r.req = REQ_MOUNT;
    else if (pick < 45) r.req = REQ_READ;
    else if (pick < 70) r.req = REQ_WRITE;
    else if (pick < 80) r.req = REQ_FLUSH;
    else if (pick < 85) r.req = REQ_DISCARD;
    else if (pick < 98) r.req = REQ_READOUT;
    else r.req = REQ_BAD;
    if (r.req == REQ_READ && tape_ready() && read_target() >= LOADED_SECTORS)
      r.req = REQ_READOUT;
    send_word(r);
  endtask

  // Driver: advance to the next word once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        tape_req_s r;
        r = pending_words.pop_front();
        in_valid <= 1'b1;
        in_req_type <= r.req;
        in_image_address <= r.addr;
        in_buffer_index <= r.bidx;
        in_data_byte <= r.dbyte;
        in_host_accepts <= r.accept;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Monitor: compare each result word with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          tape_rsp_s e;
          e = expected_rsps.pop_front();
          if (out_status != e.status) report_mismatch("status", out_status, e.status);
          if (out_read_byte != e.rbyte) report_mismatch("read_byte", out_read_byte, e.rbyte);
          if (out_flush_sector != e.fsec)
            report_mismatch("flush_sector", out_flush_sector, e.fsec);
          if (out_dirty_flag != e.dirty) report_mismatch("dirty_flag", out_dirty_flag, e.dirty);
        end
      end
    end
  end

  // Watchdog: drop the run if no word moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned cnt;
    model_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the sectors that tape traffic may touch and the head of the next one.
    for (int a = 0; a < LOADED_SECTORS * SECTOR_BYTES + NEXT_HEAD; a++)
      send(REQ_LOAD, a, 0, $urandom, 0);

    // Directed corners.
    send(REQ_LOAD, STORE_DEPTH - 1, 0, 8'hff, 0);
    send(REQ_LOAD, STORE_DEPTH, 0, 8'h00, 0);
    send(REQ_LOAD, 18'h3ffff, 0, 8'h5a, 0);
    send(REQ_BAD, 0, 0, 0, 0);
    send(REQ_READ, 0, 0, 0, 0);
    send(REQ_FLUSH, 0, 0, 0, 1);
    send(REQ_READOUT, 0, 0, 0, 0);
    send(REQ_READOUT, 0, SECTOR_BYTES - 1, 0, 0);
    send(REQ_READOUT, 0, SECTOR_BYTES, 0, 0);
    send(REQ_READOUT, 0, 10'h3ff, 0, 0);
    write_reg(CFG_SECTOR_COUNT, 0);
    send(REQ_MOUNT, 0, 0, 0, 0);
    write_reg(CFG_SECTOR_COUNT, 255);
    send(REQ_MOUNT, 0, 0, 0, 0);
    write_reg(CFG_SECTOR_COUNT, 2);
    send(REQ_MOUNT, 0, 0, 0, 0);
    send(REQ_READ, 0, 0, 0, 0);
    write_reg(CFG_MOTOR_SELECT, 0);
    send(REQ_READ, 0, 0, 0, 0);
    send(REQ_WRITE, 0, 0, 8'h11, 0);
    write_reg(CFG_WRITE_ENABLE, 1);
    write_reg(CFG_ERASE_ENABLE, 1);
    send(REQ_WRITE, 0, 0, 8'h22, 0);
    write_reg(CFG_ERASE_ENABLE, 0);
    send(REQ_WRITE, 0, 0, 8'h33, 0);
    send(REQ_READOUT, 0, 1, 0, 0);
    send(REQ_FLUSH, 0, 0, 0, 0);
    send(REQ_FLUSH, 0, 0, 0, 1);
    send(REQ_WRITE, 0, 0, 8'h44, 0);
    send(REQ_DISCARD, 0, 0, 0, 0);
    send(REQ_READ, 0, 0, 0, 0);

    // Random chunks, new register settings between them; idling pattern moves on.
    for (int p = 0; p < CHUNKS; p++) begin
      if (p < CHUNKS / 3) begin
        snd_idle_pct = 34; rcv_stall_pct = 46;
      end else if (p < 2 * CHUNKS / 3) begin
        snd_idle_pct = 46; rcv_stall_pct = 34;
      end else begin
        snd_idle_pct = 0; rcv_stall_pct = 0;
      end
      case ($urandom_range(0, 5))
        0: cnt = 1;
        1: cnt = 2;
        2: cnt = LOADED_SECTORS;
        3: cnt = MAX_SECTORS;
        4: cnt = $urandom_range(1, 255);
        default: cnt = $urandom_range(0, 1) ? 0 : 255;
      endcase
      write_reg(CFG_SECTOR_COUNT, cnt);
      if (p % 3 == 0) send(REQ_MOUNT, 0, 0, 0, 0);
      write_reg(CFG_MOTOR_SELECT, ($urandom_range(0, 5) == 0) ? $urandom_range(8, 15)
                                                             : $urandom_range(0, 7));
      write_reg(CFG_WRITE_ENABLE, $urandom_range(0, 3) != 0);
      write_reg(CFG_ERASE_ENABLE, $urandom_range(0, 4) == 0);
      for (int k = 0; k < CHUNK_WORDS; k++) random_word();
    end

    // Step into the data part, fill the rest of the buffer and run past its end,
    // then read on into the next sector of a two-sector loop.
    write_reg(CFG_SECTOR_COUNT, 2);
    send(REQ_MOUNT, 0, 0, 0, 0);
    write_reg(CFG_MOTOR_SELECT, 3);
    write_reg(CFG_WRITE_ENABLE, 1);
    write_reg(CFG_ERASE_ENABLE, 0);
    for (int k = 0; k <= DATA_START; k++) send(REQ_READ, 0, 0, 0, 0);
    for (int k = DATA_START + 1; k < SECTOR_BYTES + 10; k++) send(REQ_WRITE, 0, 0, $urandom, 0);
    for (int k = 0; k < 10; k++) send(REQ_READOUT, 0, $urandom_range(0, SECTOR_BYTES - 1), 0, 0);
    for (int k = 0; k < NEXT_HEAD; k++) send(REQ_READ, 0, 0, 0, 0);
    send(REQ_FLUSH, 0, 0, 0, 0);
    send(REQ_FLUSH, 0, 0, 0, 1);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

FILE: files.f
src/tst_pkg.sv
src/tst_ram.sv
src/tape_sector_transport.sv
tb/tb_top.sv
